### hdl/demand_page_fault_mapper_top_defines.svh
// ----------------------------------------------------------------------------
// demand page fault mapper assertion macros
// shared assertion forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef DEMAND_PAGE_FAULT_MAPPER_TOP_DEFINES_SVH
`define DEMAND_PAGE_FAULT_MAPPER_TOP_DEFINES_SVH

// same-cycle implication
`define DPFM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpfm assertion failed");

// next-cycle implication
`define DPFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpfm assertion failed");

`endif

### hdl/dpfm_pkg.sv
// ----------------------------------------------------------------------------
// dpfm_pkg
// types, constants and helpers shared by the page fault mapper modules
// ----------------------------------------------------------------------------
`default_nettype none

package dpfm_pkg;

  localparam int DPFM_ENTRIES     = 1024;
  localparam int DPFM_IDX_W       = $clog2(DPFM_ENTRIES);
  localparam int DPFM_TABLE_SLOTS = 16;
  localparam int DPFM_FRAME_W     = 20;
  localparam int DPFM_ENTRY_W     = 32;
  localparam int DPFM_DIR_LSB     = 22;
  localparam int DPFM_TBL_LSB     = 12;

  localparam logic [1:0]              DPFM_FLAGS_PRW  = 2'b11;
  localparam logic [DPFM_ENTRY_W-1:0] DPFM_DIR_ABSENT = 32'h0000_0002;

  typedef enum logic [1:0] {
    STAT_HANDLED      = 2'd0,
    STAT_PROT_IGNORED = 2'd1,
    STAT_NO_SLOT      = 2'd2
  } dpfm_status_t;

  typedef struct packed {
    logic [31:0]             fault_address;
    logic                    was_present;
    logic [DPFM_FRAME_W-1:0] table_frame;
    logic [DPFM_FRAME_W-1:0] page_frame;
  } dpfm_in_t;

  typedef struct packed {
    logic [DPFM_ENTRY_W-1:0] directory_entry;
    logic [DPFM_ENTRY_W-1:0] table_entry;
    logic                    table_allocated;
    logic                    page_allocated;
    dpfm_status_t            status;
  } dpfm_out_t;

  typedef enum logic [2:0] {
    S_DIR_INIT,
    S_IDLE,
    S_DIR_CHK,
    S_DECIDE,
    S_TBL_CLR,
    S_TBL_RD,
    S_TBL_CHK,
    S_RESULT
  } dpfm_state_t;

  // controller to datapath
  typedef struct packed {
    logic ld_in;
    logic dir_sweep;
    logic dir_chk;
    logic alloc;
    logic tbl_clr;
    logic tbl_rd;
    logic tbl_chk;
    logic res_ld;
  } dpfm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic prot;
    logic dir_present;
    logic exhausted;
  } dpfm_sts_t;

  // frame number to present, read/write entry
  function automatic logic [DPFM_ENTRY_W-1:0] make_entry(input logic [DPFM_FRAME_W-1:0] frame);
    return {frame, {(DPFM_TBL_LSB-2){1'b0}}, DPFM_FLAGS_PRW};
  endfunction

endpackage

`default_nettype wire

### hdl/dpfm_ram.sv
// ----------------------------------------------------------------------------
// dpfm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dpfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/dpfm_ctrl.sv
// ----------------------------------------------------------------------------
// dpfm_ctrl
// fault handling sequencer and result handshake for the page fault mapper
// ----------------------------------------------------------------------------
`default_nettype none

module dpfm_ctrl import dpfm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire dpfm_sts_t sts,
  output dpfm_cmd_t      cmd
);

  dpfm_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_xfer;
  logic        out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && (state_r == S_IDLE);
  // result register can take a new value when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_DIR_INIT: if (sts.cnt_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_xfer) state_nxt = S_DIR_CHK;
      S_DIR_CHK:  state_nxt = S_DECIDE;
      S_DECIDE: begin
        priority if (sts.dir_present) begin
          state_nxt = S_TBL_RD;
        end else if (sts.prot || sts.exhausted) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_TBL_CLR;
        end
      end
      S_TBL_CLR:  if (sts.cnt_last) state_nxt = S_TBL_RD;
      S_TBL_RD:   state_nxt = S_TBL_CHK;
      S_TBL_CHK:  state_nxt = S_RESULT;
      S_RESULT:   if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_DIR_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_DIR_INIT: cmd.dir_sweep = 1'b1;
      S_IDLE:     cmd.ld_in     = in_xfer;
      S_DIR_CHK:  cmd.dir_chk   = 1'b1;
      S_DECIDE:   cmd.alloc     = !sts.dir_present && !sts.prot && !sts.exhausted;
      S_TBL_CLR:  cmd.tbl_clr   = 1'b1;
      S_TBL_RD:   cmd.tbl_rd    = 1'b1;
      S_TBL_CHK:  cmd.tbl_chk   = 1'b1;
      S_RESULT:   cmd.res_ld    = out_free;
      default:    cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_DIR_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hdl/dpfm_dpath.sv
// ----------------------------------------------------------------------------
// dpfm_dpath
// directory and table stores, slot allocator, sweep counter, result register
// ----------------------------------------------------------------------------
`default_nettype none

module dpfm_dpath import dpfm_pkg::*; #(
  parameter int TABLE_SLOTS = DPFM_TABLE_SLOTS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dpfm_cmd_t               cmd,
  output dpfm_sts_t                    sts,
  input  wire dpfm_in_t                in_data,
  input  wire logic                    cfg_wr_en,
  input  wire logic [DPFM_FRAME_W-1:0] cfg_wr_data,
  output dpfm_out_t                    out_data
);

  localparam int SLOT_W    = $clog2(TABLE_SLOTS);
  localparam int NEXT_W    = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_W     = 1 + SLOT_W + DPFM_FRAME_W;
  localparam int TBL_W     = 1 + DPFM_FRAME_W;
  localparam int TBL_DEPTH = TABLE_SLOTS * DPFM_ENTRIES;
  localparam int TBL_AW    = SLOT_W + DPFM_IDX_W;

  // control state
  logic [DPFM_FRAME_W-1:0] cfg_frame_r;
  logic [DPFM_IDX_W-1:0]   cnt_r;
  logic [NEXT_W-1:0]       next_free_r;

  // per-fault working registers
  dpfm_in_t                in_r;
  logic                    dir_pres_r;
  logic [SLOT_W-1:0]       dir_slot_r;
  logic [DPFM_FRAME_W-1:0] dir_frame_r;
  logic                    tab_alloc_r;
  logic                    page_alloc_r;
  logic [DPFM_ENTRY_W-1:0] tentry_r;
  dpfm_out_t               out_r;

  logic [DPFM_IDX_W-1:0]   dir_idx;
  logic [DPFM_IDX_W-1:0]   tbl_idx;
  logic [DPFM_IDX_W-1:0]   in_dir_idx;

  logic                    dir_wr_en;
  logic [DPFM_IDX_W-1:0]   dir_wr_addr;
  logic [DIR_W-1:0]        dir_wr_data;
  logic [DIR_W-1:0]        dir_rd_data;

  logic                    tbl_wr_en;
  logic [TBL_AW-1:0]       tbl_wr_addr;
  logic [TBL_W-1:0]        tbl_wr_data;
  logic [TBL_AW-1:0]       tbl_rd_addr;
  logic [TBL_W-1:0]        tbl_rd_data;
  logic [TBL_W-1:0]        tbl_cur;
  logic                    page_wr;
  dpfm_status_t            status_val;

  assign dir_idx    = in_r.fault_address[DPFM_DIR_LSB +: DPFM_IDX_W];
  assign tbl_idx    = in_r.fault_address[DPFM_TBL_LSB +: DPFM_IDX_W];
  assign in_dir_idx = in_data.fault_address[DPFM_DIR_LSB +: DPFM_IDX_W];

  // directory store: {present, slot, frame}; entry zero lives in cfg_frame_r
  assign dir_wr_en   = cmd.dir_sweep || cmd.alloc;
  assign dir_wr_addr = cmd.dir_sweep ? cnt_r : dir_idx;
  assign dir_wr_data = cmd.dir_sweep ? '0
                                     : {1'b1, next_free_r[SLOT_W-1:0], in_r.table_frame};

  dpfm_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DPFM_ENTRIES)
  ) u_dir_ram (
    .clk     (clk),
    .wr_en   (dir_wr_en),
    .wr_addr (dir_wr_addr),
    .wr_data (dir_wr_data),
    .rd_en   (cmd.ld_in),
    .rd_addr (in_dir_idx),
    .rd_data (dir_rd_data)
  );

  // table store: {present, frame} per entry, slot-major; slot zero is the
  // fixed identity table and its ram contents are never used
  assign page_wr     = cmd.tbl_chk && !in_r.was_present && !tbl_cur[TBL_W-1];
  assign tbl_wr_en   = cmd.tbl_clr || page_wr;
  assign tbl_wr_addr = {dir_slot_r, (cmd.tbl_clr ? cnt_r : tbl_idx)};
  assign tbl_wr_data = cmd.tbl_clr ? '0 : {1'b1, in_r.page_frame};
  assign tbl_rd_addr = {dir_slot_r, tbl_idx};

  dpfm_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (cmd.tbl_rd),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  assign tbl_cur = (dir_slot_r == '0)
                 ? {1'b1, {(DPFM_FRAME_W-DPFM_IDX_W){1'b0}}, tbl_idx}
                 : tbl_rd_data;

  always_comb begin
    priority if (in_r.was_present) begin
      status_val = STAT_PROT_IGNORED;
    end else if (!dir_pres_r) begin
      status_val = STAT_NO_SLOT;
    end else begin
      status_val = STAT_HANDLED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frame_r <= '0;
      cnt_r       <= '0;
      next_free_r <= NEXT_W'(1);
    end else begin
      if (cfg_wr_en) begin
        cfg_frame_r <= cfg_wr_data;
      end
      // full sweeps wrap the counter back to zero
      if (cmd.dir_sweep || cmd.tbl_clr) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.alloc) begin
        next_free_r <= next_free_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_r         <= in_data;
      tab_alloc_r  <= 1'b0;
      page_alloc_r <= 1'b0;
      tentry_r     <= '0;
    end
    if (cmd.dir_chk) begin
      if (dir_idx == '0) begin
        dir_pres_r  <= 1'b1;
        dir_slot_r  <= '0;
        dir_frame_r <= cfg_frame_r;
      end else begin
        dir_pres_r  <= dir_rd_data[DIR_W-1];
        dir_slot_r  <= dir_rd_data[DPFM_FRAME_W +: SLOT_W];
        dir_frame_r <= dir_rd_data[DPFM_FRAME_W-1:0];
      end
    end
    if (cmd.alloc) begin
      dir_pres_r  <= 1'b1;
      dir_slot_r  <= next_free_r[SLOT_W-1:0];
      dir_frame_r <= in_r.table_frame;
      tab_alloc_r <= 1'b1;
    end
    if (cmd.tbl_chk) begin
      if (page_wr) begin
        tentry_r     <= make_entry(in_r.page_frame);
        page_alloc_r <= 1'b1;
      end else if (tbl_cur[TBL_W-1]) begin
        tentry_r <= make_entry(tbl_cur[DPFM_FRAME_W-1:0]);
      end else begin
        tentry_r <= '0;
      end
    end
    if (cmd.res_ld) begin
      out_r.directory_entry <= dir_pres_r ? make_entry(dir_frame_r) : DPFM_DIR_ABSENT;
      out_r.table_entry     <= tentry_r;
      out_r.table_allocated <= tab_alloc_r;
      out_r.page_allocated  <= page_alloc_r;
      out_r.status          <= status_val;
    end
  end

  assign sts.cnt_last    = (cnt_r == {DPFM_IDX_W{1'b1}});
  assign sts.prot        = in_r.was_present;
  assign sts.dir_present = dir_pres_r;
  assign sts.exhausted   = (next_free_r >= NEXT_W'(TABLE_SLOTS));

  assign out_data = out_r;

endmodule

`default_nettype wire

### hdl/demand_page_fault_mapper_top.sv
// flow: each fault is checked against the directory; a present entry leads to a table read
// and check, a protection fault or a full table store meeting an absent directory entry goes
// straight to the result, and a new table is first cleared, all 1024 words on the single table
// store write port; in_stall stays high until the result is loaded, one fault at a time
// reset: synchronous; a sweep then clears the directory store, during which in_stall stays
// high (configuration writes are taken throughout)
// ----------------------------------------------------------------------------
// demand_page_fault_mapper_top
// two-level page table fault handler with demand allocation of tables and pages
// ----------------------------------------------------------------------------
`default_nettype none

module demand_page_fault_mapper_top import dpfm_pkg::*; #(
  parameter int TABLE_SLOTS = DPFM_TABLE_SLOTS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire dpfm_in_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output dpfm_out_t                    out_data,
  input  wire logic                    cfg_wr_en,
  input  wire logic [DPFM_FRAME_W-1:0] cfg_wr_data
);

  dpfm_cmd_t cmd;
  dpfm_sts_t sts;

  dpfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dpfm_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

### hdl/dpfm_checker.sv
// ----------------------------------------------------------------------------
// dpfm_checker
// port-level checks on the fault mapper result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "demand_page_fault_mapper_top_defines.svh"

module dpfm_checker import dpfm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire dpfm_out_t out_data
);

  `DPFM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // ignored protection faults never consume a frame
  `DPFM_ASSERT_NOW(a_prot_no_alloc, out_valid && (out_data.status == STAT_PROT_IGNORED), !out_data.table_allocated && !out_data.page_allocated)

  `DPFM_ASSERT_NOW(a_no_slot_empty, out_valid && (out_data.status == STAT_NO_SLOT), (out_data.table_entry == '0) && !out_data.table_allocated && !out_data.page_allocated && !out_data.directory_entry[0])

  // a fresh table always receives the faulting page
  `DPFM_ASSERT_NOW(a_new_table_page, out_valid && out_data.table_allocated, out_data.page_allocated && (out_data.status == STAT_HANDLED))

  `DPFM_ASSERT_NOW(a_handled_mapped, out_valid && (out_data.status == STAT_HANDLED), (out_data.directory_entry[1:0] == DPFM_FLAGS_PRW) && (out_data.table_entry[1:0] == DPFM_FLAGS_PRW))

endmodule

bind demand_page_fault_mapper_top dpfm_checker u_dpfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
